// ----- hw/rtl/rgbwfc_pkg.sv -----
// Shared types and constants for the RGBW frame composer.
package rgbwfc_pkg;

   localparam int unsigned CHAN_W   = 8;
   localparam int unsigned CODE_W   = 10;
   localparam int unsigned GAIN_W   = 17;
   localparam int unsigned UNLOCK_W = 3;
   localparam int unsigned FRAME_W  = 32;
   localparam int unsigned DATA_W   = 32;
   localparam int unsigned ADDR_W   = 3;

   localparam int unsigned MID_DEPTH = 2;
   localparam int unsigned MID_PTR_W = 1;
   localparam int unsigned MID_CNT_W = 2;
   localparam int unsigned OUT_DEPTH = 8;
   localparam int unsigned OUT_PTR_W = 3;
   localparam int unsigned OUT_CNT_W = 4;

   // x*1023 needs 18 bits, times a 17-bit gain gives 35 bits
   localparam int unsigned SCALE_W = CHAN_W + CODE_W;
   localparam int unsigned PROD_W  = SCALE_W + GAIN_W;
   localparam int unsigned FRAC_W  = 16;
   localparam int unsigned TRUNC_W = PROD_W - FRAC_W;

   localparam logic [GAIN_W-1:0]   GAIN_RESET   = 17'h10000;
   localparam logic [UNLOCK_W-1:0] UNLOCK_RESET = 3'h7;

   localparam logic [1:0] OP_WRITE  = 2'b00;
   localparam logic [5:0] REG1_ADDR = 6'h01;

   localparam logic REG_GAIN   = 1'b0;
   localparam logic REG_UNLOCK = 1'b1;

   typedef enum logic [1:0] {
      CH_RED,
      CH_GREEN,
      CH_BLUE,
      CH_WHITE
   } chan_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] white;
   } color_type;

   typedef struct packed {
      logic      valid;
      color_type color;
   } mid_head_type;

endpackage

// ----- hw/rtl/rgbw_led_drive_frame_composer_core.sv -----
// Top level: control registers and the front/back halves of the frame composer.
//
// Usage: write an RGB color on req_red/req_green/req_blue with push while full is
// low. White is pulled out as the minimum channel, each of the four channels is
// scaled by brightness_gain to a 10-bit code, and four 32-bit register writes
// come out of the result queue in the order red, green, blue, white. Red and
// green frames select controller 0, blue and white controller 1; last_frame
// marks the white frame. Take a frame with pop while empty is low.
// The red frame passes the color queue, the scale and divide registers and the
// result queue, and the white frame follows blue. One shared scaling multiplier
// handles one channel per cycle while a color waits and the result queue has room.
// A two-entry color queue lets the input keep going while the scaler works; an
// eight-entry result queue absorbs output stalls, and when it fills the scaler
// stops, then the color queue fills and full rises.
// Registers (APB, write at psel/penable/pwrite): 0x0 brightness_gain,
// 0x4 unlock_bits. Reset empties both queues, zeroes the kept codes and sets
// full-scale gain and unlock bits 7.
module rgbw_led_drive_frame_composer_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   output logic                               full,
   input  logic [rgbwfc_pkg::CHAN_W-1:0]      req_red,
   input  logic [rgbwfc_pkg::CHAN_W-1:0]      req_green,
   input  logic [rgbwfc_pkg::CHAN_W-1:0]      req_blue,
   output logic                               empty,
   input  logic                               pop,
   output logic [rgbwfc_pkg::FRAME_W-1:0]     rsp_spi_frame,
   output logic                               rsp_controller_select,
   output logic                               rsp_last_frame,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [rgbwfc_pkg::ADDR_W-1:0]      paddr,
   input  logic [rgbwfc_pkg::DATA_W-1:0]      pwdata,
   output logic [rgbwfc_pkg::DATA_W-1:0]      prdata,
   output logic                               pready
);

   logic [rgbwfc_pkg::GAIN_W-1:0]    gain_ff, gain_in;
   logic [rgbwfc_pkg::UNLOCK_W-1:0]  unlock_ff, unlock_in;
   logic                             csr_write;
   logic                             csr_sel;
   rgbwfc_pkg::mid_head_type         mid_head;
   logic                             mid_pop;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_sel   = paddr[2];

   always_comb begin
      gain_in   = gain_ff;
      unlock_in = unlock_ff;
      if (csr_write) begin
         unique case (csr_sel)
            rgbwfc_pkg::REG_GAIN:   gain_in   = pwdata[rgbwfc_pkg::GAIN_W-1:0];
            rgbwfc_pkg::REG_UNLOCK: unlock_in = pwdata[rgbwfc_pkg::UNLOCK_W-1:0];
            default:                gain_in   = gain_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_sel)
         rgbwfc_pkg::REG_GAIN:   prdata = rgbwfc_pkg::DATA_W'(gain_ff);
         rgbwfc_pkg::REG_UNLOCK: prdata = rgbwfc_pkg::DATA_W'(unlock_ff);
         default:                prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff   <= rgbwfc_pkg::GAIN_RESET;
         unlock_ff <= rgbwfc_pkg::UNLOCK_RESET;
      end else begin
         gain_ff   <= gain_in;
         unlock_ff <= unlock_in;
      end
   end

   rgbwfc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_red   (req_red),
      .req_green (req_green),
      .req_blue  (req_blue),
      .mid_pop   (mid_pop),
      .mid_head  (mid_head)
   );

   rgbwfc_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .mid_head              (mid_head),
      .mid_pop               (mid_pop),
      .gain                  (gain_ff),
      .unlock                (unlock_ff),
      .pop                   (pop),
      .empty                 (empty),
      .rsp_spi_frame         (rsp_spi_frame),
      .rsp_controller_select (rsp_controller_select),
      .rsp_last_frame        (rsp_last_frame)
   );

endmodule

// ----- hw/rtl/rgbwfc_front.sv -----
// Front end: takes colors, extracts white, queues them for the scaler.
module rgbwfc_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   output logic                            full,
   input  logic [rgbwfc_pkg::CHAN_W-1:0]   req_red,
   input  logic [rgbwfc_pkg::CHAN_W-1:0]   req_green,
   input  logic [rgbwfc_pkg::CHAN_W-1:0]   req_blue,
   input  logic                            mid_pop,
   output rgbwfc_pkg::mid_head_type        mid_head
);

   rgbwfc_pkg::color_type                  mid_q_ff [rgbwfc_pkg::MID_DEPTH];
   logic [rgbwfc_pkg::MID_PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [rgbwfc_pkg::MID_PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [rgbwfc_pkg::MID_CNT_W-1:0]       cnt_ff, cnt_in;
   logic [rgbwfc_pkg::CHAN_W-1:0]          white;
   rgbwfc_pkg::color_type                  color_in;
   logic                                   accept;

   always_comb begin
      white = req_red;
      if (req_green < white) begin
         white = req_green;
      end
      if (req_blue < white) begin
         white = req_blue;
      end
      color_in.red   = req_red - white;
      color_in.green = req_green - white;
      color_in.blue  = req_blue - white;
      color_in.white = white;
   end

   assign full   = (cnt_ff == rgbwfc_pkg::MID_CNT_W'(rgbwfc_pkg::MID_DEPTH));
   assign accept = push && !full;

   assign mid_head.valid = (cnt_ff != '0);
   assign mid_head.color = mid_q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = accept ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = mid_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (accept && !mid_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!accept && mid_pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mid_q_ff[wr_ptr_ff] <= color_in;
      end
   end

endmodule

// ----- hw/rtl/rgbwfc_back.sv -----
// Back end: scales a channel per cycle if not stalled; composes and queues frames.
module rgbwfc_back (
   input  logic                              clock,
   input  logic                              reset,
   input  rgbwfc_pkg::mid_head_type          mid_head,
   output logic                              mid_pop,
   input  logic [rgbwfc_pkg::GAIN_W-1:0]     gain,
   input  logic [rgbwfc_pkg::UNLOCK_W-1:0]   unlock,
   input  logic                              pop,
   output logic                              empty,
   output logic [rgbwfc_pkg::FRAME_W-1:0]    rsp_spi_frame,
   output logic                              rsp_controller_select,
   output logic                              rsp_last_frame
);

   localparam int unsigned ITEM_W = rgbwfc_pkg::FRAME_W + 2;

   // floor(t/255) saturated at the code maximum; t*257/65536 is low by at most one
   function automatic logic [rgbwfc_pkg::CODE_W-1:0] div255_sat(
      input logic [rgbwfc_pkg::TRUNC_W-1:0] t
   );
      logic [rgbwfc_pkg::TRUNC_W+8:0]   est;
      logic [rgbwfc_pkg::CODE_W-1:0]    q0;
      logic [rgbwfc_pkg::TRUNC_W-1:0]   rem;
      est = {t, 8'b0} + (rgbwfc_pkg::TRUNC_W+9)'(t);
      q0  = est[rgbwfc_pkg::CODE_W+15:16];
      rem = t - (({(rgbwfc_pkg::TRUNC_W-rgbwfc_pkg::CODE_W)'(0), q0} << 8)
                 - rgbwfc_pkg::TRUNC_W'(q0));
      if (t >= rgbwfc_pkg::TRUNC_W'(1024 * 255)) begin
         return '1;
      end else if (rem >= rgbwfc_pkg::TRUNC_W'(255)) begin
         return q0 + 1'b1;
      end else begin
         return q0;
      end
   endfunction

   function automatic logic [rgbwfc_pkg::FRAME_W-1:0] make_frame(
      input logic [rgbwfc_pkg::CODE_W-1:0]   buck1,
      input logic [rgbwfc_pkg::CODE_W-1:0]   buck2,
      input logic [rgbwfc_pkg::UNLOCK_W-1:0] bits
   );
      logic [22:0] d;
      d = {buck1, buck2, bits};
      return {rgbwfc_pkg::OP_WRITE, rgbwfc_pkg::REG1_ADDR, d, ^d};
   endfunction

   rgbwfc_pkg::chan_type                  chan_ff, chan_in;
   logic                                  issue;
   logic [rgbwfc_pkg::OUT_CNT_W-1:0]      committed;
   logic [rgbwfc_pkg::CHAN_W-1:0]         x_sel;
   logic [rgbwfc_pkg::SCALE_W-1:0]        x_scaled;

   logic                                  a_vld_ff;
   rgbwfc_pkg::chan_type                  a_chan_ff;
   logic [rgbwfc_pkg::PROD_W-1:0]         a_prod_ff, a_prod_in;

   logic                                  b_vld_ff;
   rgbwfc_pkg::chan_type                  b_chan_ff;
   logic [rgbwfc_pkg::CODE_W-1:0]         b_code_ff;

   logic [rgbwfc_pkg::CODE_W-1:0]         red_code_ff, green_code_ff;
   logic [rgbwfc_pkg::CODE_W-1:0]         blue_code_ff, white_code_ff;

   logic [ITEM_W-1:0]                     out_q_ff [rgbwfc_pkg::OUT_DEPTH];
   logic [rgbwfc_pkg::OUT_PTR_W-1:0]      out_wr_ff, out_wr_in;
   logic [rgbwfc_pkg::OUT_PTR_W-1:0]      out_rd_ff, out_rd_in;
   logic [rgbwfc_pkg::OUT_CNT_W-1:0]      out_cnt_ff, out_cnt_in;
   logic                                  out_push, out_pop;
   logic [ITEM_W-1:0]                     out_item;
   logic [ITEM_W-1:0]                     head_item;

   // queue slots already spoken for, including frames still in the pipe
   assign committed = out_cnt_ff + rgbwfc_pkg::OUT_CNT_W'(a_vld_ff)
                      + rgbwfc_pkg::OUT_CNT_W'(b_vld_ff);
   assign issue   = mid_head.valid
                    && (committed < rgbwfc_pkg::OUT_CNT_W'(rgbwfc_pkg::OUT_DEPTH));
   assign mid_pop = issue && (chan_ff == rgbwfc_pkg::CH_WHITE);
   assign chan_in = issue ? rgbwfc_pkg::chan_type'(chan_ff + 2'd1) : chan_ff;

   always_comb begin
      unique case (chan_ff)
         rgbwfc_pkg::CH_RED:   x_sel = mid_head.color.red;
         rgbwfc_pkg::CH_GREEN: x_sel = mid_head.color.green;
         rgbwfc_pkg::CH_BLUE:  x_sel = mid_head.color.blue;
         rgbwfc_pkg::CH_WHITE: x_sel = mid_head.color.white;
         default:              x_sel = mid_head.color.red;
      endcase
   end

   assign x_scaled  = {x_sel, 10'b0} - rgbwfc_pkg::SCALE_W'(x_sel);
   assign a_prod_in = rgbwfc_pkg::PROD_W'(x_scaled) * rgbwfc_pkg::PROD_W'(gain);

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff  <= rgbwfc_pkg::CH_RED;
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
      end else begin
         chan_ff  <= chan_in;
         a_vld_ff <= issue;
         b_vld_ff <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_chan_ff <= chan_ff;
      a_prod_ff <= a_prod_in;
      b_chan_ff <= a_chan_ff;
      b_code_ff <= div255_sat(a_prod_ff[rgbwfc_pkg::PROD_W-1:rgbwfc_pkg::FRAC_W]);
   end

   assign out_push = b_vld_ff;

   // red and green frames go to controller 0, blue and white to controller 1
   always_comb begin
      unique case (b_chan_ff)
         rgbwfc_pkg::CH_RED:
            out_item = {make_frame(b_code_ff, green_code_ff, unlock), 1'b0, 1'b0};
         rgbwfc_pkg::CH_GREEN:
            out_item = {make_frame(red_code_ff, b_code_ff, unlock), 1'b0, 1'b0};
         rgbwfc_pkg::CH_BLUE:
            out_item = {make_frame(white_code_ff, b_code_ff, unlock), 1'b1, 1'b0};
         rgbwfc_pkg::CH_WHITE:
            out_item = {make_frame(b_code_ff, blue_code_ff, unlock), 1'b1, 1'b1};
         default:
            out_item = {make_frame(b_code_ff, green_code_ff, unlock), 1'b0, 1'b0};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         red_code_ff   <= '0;
         green_code_ff <= '0;
         blue_code_ff  <= '0;
         white_code_ff <= '0;
      end else if (out_push) begin
         case (b_chan_ff)
            rgbwfc_pkg::CH_RED:   red_code_ff   <= b_code_ff;
            rgbwfc_pkg::CH_GREEN: green_code_ff <= b_code_ff;
            rgbwfc_pkg::CH_BLUE:  blue_code_ff  <= b_code_ff;
            rgbwfc_pkg::CH_WHITE: white_code_ff <= b_code_ff;
            default:              red_code_ff   <= b_code_ff;
         endcase
      end
   end

   assign empty   = (out_cnt_ff == '0);
   assign out_pop = pop && !empty;

   always_comb begin
      out_wr_in  = out_push ? out_wr_ff + 1'b1 : out_wr_ff;
      out_rd_in  = out_pop ? out_rd_ff + 1'b1 : out_rd_ff;
      out_cnt_in = out_cnt_ff;
      if (out_push && !out_pop) begin
         out_cnt_in = out_cnt_ff + 1'b1;
      end else if (!out_push && out_pop) begin
         out_cnt_in = out_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_wr_ff  <= '0;
         out_rd_ff  <= '0;
         out_cnt_ff <= '0;
      end else begin
         out_wr_ff  <= out_wr_in;
         out_rd_ff  <= out_rd_in;
         out_cnt_ff <= out_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_push) begin
         out_q_ff[out_wr_ff] <= out_item;
      end
   end

   assign head_item             = out_q_ff[out_rd_ff];
   assign rsp_spi_frame         = head_item[ITEM_W-1:2];
   assign rsp_controller_select = head_item[1];
   assign rsp_last_frame        = head_item[0];

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      committed <= rgbwfc_pkg::OUT_CNT_W'(rgbwfc_pkg::OUT_DEPTH))
      else $error("result queue overcommitted");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      out_push |-> (out_cnt_ff < rgbwfc_pkg::OUT_CNT_W'(rgbwfc_pkg::OUT_DEPTH))
                   || out_pop)
      else $error("frame pushed into full result queue");

   a_white_pops: assert property (@(posedge clock) disable iff (reset)
      mid_pop |=> (chan_ff == rgbwfc_pkg::CH_RED) && a_vld_ff
                  && (a_chan_ff == rgbwfc_pkg::CH_WHITE))
      else $error("color released before its white channel issued");
`endif

endmodule

// ----- tb/tb_top.sv -----
// Self-checking bench for the RGBW frame composer: colors in, checked SPI frames out.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import rgbwfc_pkg::*;

   localparam int CLK_HALF       = 4;
   localparam int HOLD_CYCLES    = 120;
   localparam int WATCHDOG_LIMIT = 1500;
   localparam int PHASE_COLORS   = 45;
   localparam logic [GAIN_W-1:0] GAIN_MAX = '1;

   typedef struct packed {
      logic [FRAME_W-1:0] frame;
      logic               sel;
      logic               last;
   } frame_rec_type;

   // Predicts the four frames of each color and holds them until they come out.
   class led_frame_model_type;
      logic [CODE_W-1:0]   red_code, green_code, blue_code, white_code;
      logic [GAIN_W-1:0]   gain;
      logic [UNLOCK_W-1:0] unlock;
      frame_rec_type       pending_frames[$];
      int                  errors;
      int                  colors_taken;
      int                  frames_matched;

      function new();
         red_code       = '0;
         green_code     = '0;
         blue_code      = '0;
         white_code     = '0;
         gain           = GAIN_RESET;
         unlock         = UNLOCK_RESET;
         errors         = 0;
         colors_taken   = 0;
         frames_matched = 0;
      endfunction

      function logic [CODE_W-1:0] scale_channel(logic [CHAN_W-1:0] x);
         longint unsigned prod;
         longint unsigned q;
         prod = 64'(x);
         prod = prod * 1023 * gain;
         q = prod / (255 * 65536);
         if (q > 1023)
            q = 1023;
         return q[CODE_W-1:0];
      endfunction

      function logic [FRAME_W-1:0] compose(logic [CODE_W-1:0] buck1, logic [CODE_W-1:0] buck2);
         logic [23:0] d;
         d = {buck1, buck2, unlock, 1'b0};
         d[0] = ^d[23:1];
         return {OP_WRITE, REG1_ADDR, d};
      endfunction

      function void take_color(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                               logic [CHAN_W-1:0] b);
         logic [CHAN_W-1:0] w;
         w = r;
         if (g < w)
            w = g;
         if (b < w)
            w = b;
         // red and blue frames go out with the green and white codes kept from before
         red_code = scale_channel(r - w);
         pending_frames.push_back({compose(red_code, green_code), 1'b0, 1'b0});
         green_code = scale_channel(g - w);
         pending_frames.push_back({compose(red_code, green_code), 1'b0, 1'b0});
         blue_code = scale_channel(b - w);
         pending_frames.push_back({compose(white_code, blue_code), 1'b1, 1'b0});
         white_code = scale_channel(w);
         pending_frames.push_back({compose(white_code, blue_code), 1'b1, 1'b1});
         colors_taken++;
      endfunction

      function void match_frame(logic [FRAME_W-1:0] frame, logic sel, logic last);
         frame_rec_type want;
         if (pending_frames.size() == 0) begin
            $display("%0t: unexpected frame %h sel %b last %b", $time, frame, sel, last);
            errors++;
            return;
         end
         want = pending_frames.pop_front();
         if (frame !== want.frame) begin
            $display("%0t: spi_frame expected %h actual %h", $time, want.frame, frame);
            errors++;
         end
         if (sel !== want.sel) begin
            $display("%0t: controller_select expected %b actual %b", $time, want.sel, sel);
            errors++;
         end
         if (last !== want.last) begin
            $display("%0t: last_frame expected %b actual %b", $time, want.last, last);
            errors++;
         end
         frames_matched++;
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                push = 1'b0;
   logic                full;
   logic [CHAN_W-1:0]   req_red = '0;
   logic [CHAN_W-1:0]   req_green = '0;
   logic [CHAN_W-1:0]   req_blue = '0;
   logic                empty;
   logic                pop = 1'b0;
   logic [FRAME_W-1:0]  rsp_spi_frame;
   logic                rsp_controller_select;
   logic                rsp_last_frame;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [ADDR_W-1:0]   paddr = '0;
   logic [DATA_W-1:0]   pwdata = '0;
   logic [DATA_W-1:0]   prdata;
   logic                pready;

   led_frame_model_type model = new();
   int  send_gap_max = 10;
   int  recv_gap_max = 10;
   bit  hold_request = 1'b0;
   int  gain_settings = 0;
   int  idle_cycles_ff = 0;

   rgbw_led_drive_frame_composer_core u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .push                  (push),
      .full                  (full),
      .req_red               (req_red),
      .req_green             (req_green),
      .req_blue              (req_blue),
      .empty                 (empty),
      .pop                   (pop),
      .rsp_spi_frame         (rsp_spi_frame),
      .rsp_controller_select (rsp_controller_select),
      .rsp_last_frame        (rsp_last_frame),
      .psel                  (psel),
      .penable               (penable),
      .pwrite                (pwrite),
      .paddr                 (paddr),
      .pwdata                (pwdata),
      .prdata                (prdata),
      .pready                (pready)
   );

   initial begin
      forever #(CLK_HALF) clock = ~clock;
   end

   task automatic csr_write(input logic reg_idx, input logic [DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_check(input logic reg_idx, input logic [DATA_W-1:0] want);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {reg_idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== want) begin
         $display("%0t: register %0d read expected %h actual %h", $time, reg_idx, want, prdata);
         model.errors++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Only called with the block drained.
   task automatic set_regs(input logic [GAIN_W-1:0] gain, input logic [UNLOCK_W-1:0] unlock);
      csr_write(REG_GAIN, DATA_W'(gain));
      csr_write(REG_UNLOCK, DATA_W'(unlock));
      model.gain   = gain;
      model.unlock = unlock;
      gain_settings++;
      csr_check(REG_GAIN, DATA_W'(gain));
      csr_check(REG_UNLOCK, DATA_W'(unlock));
   endtask

   task automatic push_color(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                             input logic [CHAN_W-1:0] b);
      int gap;
      gap = $urandom_range(0, send_gap_max);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push      <= 1'b1;
      req_red   <= r;
      req_green <= g;
      req_blue  <= b;
      @(posedge clock);
      while (full) @(posedge clock);
      model.take_color(r, g, b);
   endtask

   task automatic push_random_color();
      logic [CHAN_W-1:0] r, g, b;
      int shape;
      shape = $urandom_range(0, 9);
      r = CHAN_W'($urandom_range(0, 255));
      g = CHAN_W'($urandom_range(0, 255));
      b = CHAN_W'($urandom_range(0, 255));
      case (shape)
         0: begin
            g = r;
            b = r;
         end
         1: begin
            case ($urandom_range(0, 2))
               0: r = '0;
               1: g = '0;
               default: b = '0;
            endcase
         end
         2: begin
            r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            g = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         end
         default: ;
      endcase
      push_color(r, g, b);
   endtask

   // Sender stops and waits for every predicted frame to come out.
   task automatic drain();
      push <= 1'b0;
      do @(posedge clock); while (model.pending_frames.size() != 0);
   endtask

   task automatic take_frame();
      int gap;
      if (hold_request) begin
         hold_request = 1'b0;
         pop <= 1'b0;
         repeat (HOLD_CYCLES) @(posedge clock);
      end else begin
         gap = $urandom_range(0, recv_gap_max);
         if (gap > 0) begin
            pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      pop <= 1'b1;
      @(posedge clock);
      while (empty) @(posedge clock);
      model.match_frame(rsp_spi_frame, rsp_controller_select, rsp_last_frame);
   endtask

   initial begin
      @(negedge reset);
      forever take_frame();
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty) || psel) begin
         idle_cycles_ff <= 0;
      end else begin
         idle_cycles_ff <= idle_cycles_ff + 1;
         if (idle_cycles_ff >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles, %0d frames outstanding", $time,
                     idle_cycles_ff, model.pending_frames.size());
            $display("Some tests failed");
            $finish;
         end
      end
   end

   initial begin
      logic [GAIN_W-1:0]   gain;
      logic [UNLOCK_W-1:0] unlock;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_check(REG_GAIN, DATA_W'(GAIN_RESET));
      csr_check(REG_UNLOCK, DATA_W'(UNLOCK_RESET));

      // directed colors at reset settings
      push_color(8'd0, 8'd0, 8'd0);
      push_color(8'd255, 8'd255, 8'd255);
      push_color(8'd255, 8'd0, 8'd0);
      push_color(8'd0, 8'd255, 8'd0);
      push_color(8'd0, 8'd0, 8'd255);
      push_color(8'd255, 8'd255, 8'd0);
      push_color(8'd0, 8'd255, 8'd255);
      push_color(8'd1, 8'd2, 8'd3);
      push_color(8'd170, 8'd85, 8'd51);
      push_color(8'd255, 8'd254, 8'd253);
      push_color(8'd128, 8'd64, 8'd200);
      push_color(8'd0, 8'd0, 8'd0);
      drain();

      // gain above full scale, codes saturate
      set_regs(GAIN_MAX, 3'd0);
      push_color(8'd255, 8'd0, 8'd0);
      push_color(8'd128, 8'd127, 8'd0);
      push_color(8'd200, 8'd100, 8'd50);
      push_color(8'd255, 8'd255, 8'd255);
      drain();

      set_regs('0, 3'd5);
      push_color(8'd255, 8'd128, 8'd0);
      push_color(8'd90, 8'd90, 8'd90);
      drain();

      set_regs(GAIN_W'(1), 3'd2);
      push_color(8'd255, 8'd0, 8'd255);
      push_color(8'd0, 8'd1, 8'd0);
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         unlock = UNLOCK_W'($urandom_range(0, 7));
         case (phase)
            0: gain = GAIN_RESET;
            1: gain = GAIN_W'(32768);
            2: gain = GAIN_W'($urandom_range(0, 131071));
            4: gain = GAIN_W'($urandom_range(65536, 131071));
            default: gain = GAIN_W'($urandom_range(0, 65536));
         endcase
         set_regs(gain, unlock);
         send_gap_max = (phase == 1 || phase == 3) ? 0 : 10;
         recv_gap_max = (phase == 1) ? 0 : 10;
         // receiver stalls long while the sender keeps pushing, so full rises
         if (phase == 3)
            hold_request = 1'b1;
         for (int n = 0; n < PHASE_COLORS; n++)
            push_random_color();
         drain();
      end
      send_gap_max = 10;
      recv_gap_max = 10;

      repeat (12) @(posedge clock);
      $display("Ran %0d colors through %0d register settings, %0d frames checked.",
               model.colors_taken, gain_settings + 1, model.frames_matched);
      $display("Covered saturating gain, zero gain, back-pressure and no-gap streaming.");
      if (model.errors == 0 && model.pending_frames.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hw/rtl/rgbwfc_pkg.sv
hw/rtl/rgbwfc_front.sv
hw/rtl/rgbwfc_back.sv
hw/rtl/rgbw_led_drive_frame_composer_core.sv
tb/tb_top.sv
